// ===== rtl/core/rffefrm_pkg.sv =====
// Shared types and constants for the dual-lane RFFE register-write framer.
// No dependencies; imported by rffefrm_lane and dual_lane_rffe_write_framer.
`default_nettype none

package rffefrm_pkg;

   localparam int USID_W   = 4;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 8;
   localparam int CMD_W    = 12;
   localparam int FRAME_W  = 23;
   localparam int FNUM_W   = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [2:0]        CMD_REG_WRITE = 3'b010;
   localparam logic [FNUM_W-1:0] FRAME_LAST    = 2'd3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FIRST_DEVICE_ID  = 3'd0,
      REG_SECOND_DEVICE_ID = 3'd1,
      REG_TRIGGER_ADDRESS  = 3'd2,
      REG_TRIGGER_VALUE    = 3'd3,
      REG_DATA_ADDRESS     = 3'd4
   } csr_index_type;

   localparam logic [USID_W-1:0] FIRST_ID_RST    = 4'h6;
   localparam logic [USID_W-1:0] SECOND_ID_RST   = 4'h7;
   localparam logic [ADDR_W-1:0] TRIG_ADDR_RST   = 5'h1C;
   localparam logic [DATA_W-1:0] TRIG_VALUE_RST  = 8'h00;
   localparam logic [ADDR_W-1:0] DATA_ADDR_RST   = 5'h01;

   // fields one lane needs to build a register-write frame
   typedef struct packed {
      logic [USID_W-1:0] usid;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } frame_fields_type;

endpackage

`default_nettype wire

// ===== rtl/core/rffefrm_lane.sv =====
// One lane's frame builder: USID, command, address, data and both odd parities.
// Depends on rffefrm_pkg.
`default_nettype none

module rffefrm_lane (
   input  rffefrm_pkg::frame_fields_type        fields,
   output logic [rffefrm_pkg::FRAME_W-1:0]      frame
);
   import rffefrm_pkg::*;

   logic [CMD_W-1:0] cmd;
   logic             cmd_par;
   logic             data_par;

   assign cmd      = {fields.usid, CMD_REG_WRITE, fields.addr};
   assign cmd_par  = ~^cmd;
   assign data_par = ~^fields.data;
   // trailing zero is the bus park bit
   assign frame    = {cmd, cmd_par, fields.data, data_par, 1'b0};

endmodule

`default_nettype wire

// ===== rtl/core/dual_lane_rffe_write_framer.sv =====
// Each accepted item (four state bytes) yields four results, one a cycle when the
// result side does not stall: trigger write to the first device, its data write
// (lane A byte 0, lane B byte 1), trigger write to the second device, its data
// write (bytes 2 and 3). The next item is taken in the cycle the fourth frame of
// the current one moves to the output register, not before. An accepted item is
// held in the item registers, and each frame is then registered in the output
// register once it is free. Two lane builders work side by side; the output
// register merges them with the frame number and last flag. Configuration
// writes are always accepted (csr_ready high) and must only happen while the
// block is idle.
// Depends on rffefrm_pkg and rffefrm_lane.
`default_nettype none

module dual_lane_rffe_write_framer (
   input  logic                                   clock,
   input  logic                                   reset,
   // item input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_first_lane_a_value,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_first_lane_b_value,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_second_lane_a_value,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_second_lane_b_value,
   // frame output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [rffefrm_pkg::FNUM_W-1:0]         rsp_frame_number,
   output logic [rffefrm_pkg::FRAME_W-1:0]        rsp_lane_a_frame,
   output logic [rffefrm_pkg::FRAME_W-1:0]        rsp_lane_b_frame,
   output logic                                   rsp_last_frame,
   // configuration
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rffefrm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rffefrm_pkg::DATA_W-1:0]         csr_wdata
);
   import rffefrm_pkg::*;

   // configuration registers
   logic [USID_W-1:0] first_id_ff;
   logic [USID_W-1:0] second_id_ff;
   logic [ADDR_W-1:0] trig_addr_ff;
   logic [DATA_W-1:0] trig_value_ff;
   logic [ADDR_W-1:0] data_addr_ff;

   // held item and frame sequencing
   logic              item_valid_ff, item_valid_in;
   logic [FNUM_W-1:0] frame_cnt_ff, frame_cnt_in;
   logic [DATA_W-1:0] byte0_ff, byte1_ff, byte2_ff, byte3_ff;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [FNUM_W-1:0]  out_fnum_ff;
   logic [FRAME_W-1:0] out_a_ff, out_b_ff;
   logic               out_last_ff;

   logic req_take, rsp_take, out_free, issue, item_done, csr_take;
   frame_fields_type   fields_a, fields_b;
   logic [FRAME_W-1:0] frame_a, frame_b;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff   <= FIRST_ID_RST;
         second_id_ff  <= SECOND_ID_RST;
         trig_addr_ff  <= TRIG_ADDR_RST;
         trig_value_ff <= TRIG_VALUE_RST;
         data_addr_ff  <= DATA_ADDR_RST;
      end else if (csr_take) begin
         unique case (csr_index)
            REG_FIRST_DEVICE_ID:  first_id_ff   <= csr_wdata[USID_W-1:0];
            REG_SECOND_DEVICE_ID: second_id_ff  <= csr_wdata[USID_W-1:0];
            REG_TRIGGER_ADDRESS:  trig_addr_ff  <= csr_wdata[ADDR_W-1:0];
            REG_TRIGGER_VALUE:    trig_value_ff <= csr_wdata;
            REG_DATA_ADDRESS:     data_addr_ff  <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign issue     = item_valid_ff && out_free;
   assign item_done = issue && (frame_cnt_ff == FRAME_LAST);
   assign req_stall = item_valid_ff && !item_done;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      frame_cnt_in  = frame_cnt_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
         frame_cnt_in  = '0;
      end else if (issue) begin
         item_valid_in = !item_done;
         frame_cnt_in  = frame_cnt_ff + 1'b1;
      end
      out_valid_in = out_valid_ff;
      if (issue) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         frame_cnt_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         frame_cnt_ff  <= frame_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte0_ff <= req_first_lane_a_value;
         byte1_ff <= req_first_lane_b_value;
         byte2_ff <= req_second_lane_a_value;
         byte3_ff <= req_second_lane_b_value;
      end
   end

   // frame_cnt bit 1 picks the device, bit 0 picks data write over trigger write
   always_comb begin
      fields_a.usid = frame_cnt_ff[1] ? second_id_ff : first_id_ff;
      fields_a.addr = frame_cnt_ff[0] ? data_addr_ff : trig_addr_ff;
      fields_a.data = !frame_cnt_ff[0] ? trig_value_ff :
                      (frame_cnt_ff[1] ? byte2_ff : byte0_ff);
      fields_b.usid = fields_a.usid;
      fields_b.addr = fields_a.addr;
      fields_b.data = !frame_cnt_ff[0] ? trig_value_ff :
                      (frame_cnt_ff[1] ? byte3_ff : byte1_ff);
   end

   rffefrm_lane u_lane_a (
      .fields (fields_a),
      .frame  (frame_a)
   );

   rffefrm_lane u_lane_b (
      .fields (fields_b),
      .frame  (frame_b)
   );

   // merge stage
   always_ff @(posedge clock) begin
      if (issue) begin
         out_fnum_ff <= frame_cnt_ff;
         out_a_ff    <= frame_a;
         out_b_ff    <= frame_b;
         out_last_ff <= (frame_cnt_ff == FRAME_LAST);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_number = out_fnum_ff;
   assign rsp_lane_a_frame = out_a_ff;
   assign rsp_lane_b_frame = out_b_ff;
   assign rsp_last_frame   = out_last_ff;

   // trigger frames are identical on both lanes
   a_trig_same : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_fnum_ff[0]) |-> (out_a_ff == out_b_ff))
      else $error("trigger frame differs between lanes");

   // command field plus its parity bit has odd weight
   a_cmd_parity : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (^out_a_ff[FRAME_W-1:10] == 1'b1))
      else $error("command parity wrong on lane A");

   // frames of one item follow without gaps
   a_frame_seq : assert property (@(posedge clock) disable iff (reset)
      (rsp_take && (out_fnum_ff != FRAME_LAST)) |=>
      (out_valid_ff && (out_fnum_ff == $past(out_fnum_ff) + 2'd1)))
      else $error("frame sequence broken");

   // a new item starts at frame zero
   a_item_start : assert property (@(posedge clock) disable iff (reset)
      req_take |=> (item_valid_ff && (frame_cnt_ff == '0)))
      else $error("item not loaded at frame zero");

   // last flag matches frame number
   a_last_flag : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_last_ff == (out_fnum_ff == FRAME_LAST)))
      else $error("last flag mismatch");

endmodule

`default_nettype wire

// ===== verif/rffe_frame_checker.sv =====
`timescale 1ns / 1ps
// Watches the item, frame and register channels of the dual-lane RFFE framer.
// Predicts the four frames per accepted item and checks them in order.
// Depends on rffefrm_pkg.

module rffe_frame_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_first_lane_a_value,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_first_lane_b_value,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_second_lane_a_value,
   input  logic [rffefrm_pkg::DATA_W-1:0]         req_second_lane_b_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [rffefrm_pkg::FNUM_W-1:0]         rsp_frame_number,
   input  logic [rffefrm_pkg::FRAME_W-1:0]        rsp_lane_a_frame,
   input  logic [rffefrm_pkg::FRAME_W-1:0]        rsp_lane_b_frame,
   input  logic                                   rsp_last_frame,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [rffefrm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rffefrm_pkg::DATA_W-1:0]         csr_wdata,
   output int                                     fail_count,
   output int                                     pending
);
   import rffefrm_pkg::*;

   typedef struct packed {
      logic [FNUM_W-1:0]  number;
      logic [FRAME_W-1:0] lane_a;
      logic [FRAME_W-1:0] lane_b;
      logic               last;
   } frame_result_type;

   frame_result_type expected_frames[$];

   logic [USID_W-1:0] first_usid;
   logic [USID_W-1:0] second_usid;
   logic [ADDR_W-1:0] trig_addr;
   logic [DATA_W-1:0] trig_data;
   logic [ADDR_W-1:0] state_addr;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // USID, write command, address, odd parity, data, odd parity, bus park
   function automatic logic [FRAME_W-1:0] build_write_frame(input logic [USID_W-1:0] usid,
                                                            input logic [ADDR_W-1:0] addr,
                                                            input logic [DATA_W-1:0] data);
      logic [CMD_W-1:0] cmd;
      cmd = {usid, CMD_REG_WRITE, addr};
      return {cmd, ~^cmd, data, ~^data, 1'b0};
   endfunction

   task automatic predict_frames(input logic [DATA_W-1:0] a0, input logic [DATA_W-1:0] b0,
                                 input logic [DATA_W-1:0] a1, input logic [DATA_W-1:0] b1);
      frame_result_type fr;
      logic [USID_W-1:0] usid;
      for (int k = 0; k < 4; k++) begin
         usid = (k < 2) ? first_usid : second_usid;
         fr.number = k[FNUM_W-1:0];
         fr.last = (fr.number == FRAME_LAST);
         if (k % 2 == 0) begin
            // trigger frames are identical on both lanes
            fr.lane_a = build_write_frame(usid, trig_addr, trig_data);
            fr.lane_b = fr.lane_a;
         end else begin
            fr.lane_a = build_write_frame(usid, state_addr, (k < 2) ? a0 : a1);
            fr.lane_b = build_write_frame(usid, state_addr, (k < 2) ? b0 : b1);
         end
         expected_frames.push_back(fr);
      end
   endtask

   task automatic check_field(input string name, input logic [FRAME_W-1:0] want,
                              input logic [FRAME_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         first_usid  = FIRST_ID_RST;
         second_usid = SECOND_ID_RST;
         trig_addr   = TRIG_ADDR_RST;
         trig_data   = TRIG_VALUE_RST;
         state_addr  = DATA_ADDR_RST;
         expected_frames.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_FIRST_DEVICE_ID:  first_usid  = csr_wdata[USID_W-1:0];
               REG_SECOND_DEVICE_ID: second_usid = csr_wdata[USID_W-1:0];
               REG_TRIGGER_ADDRESS:  trig_addr   = csr_wdata[ADDR_W-1:0];
               REG_TRIGGER_VALUE:    trig_data   = csr_wdata;
               REG_DATA_ADDRESS:     state_addr  = csr_wdata[ADDR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_frames(req_first_lane_a_value, req_first_lane_b_value,
                           req_second_lane_a_value, req_second_lane_b_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               fail_count++;
               $display("%0t: frame mismatch, expected none, actual %h %h %h %h", $time,
                        rsp_frame_number, rsp_lane_a_frame, rsp_lane_b_frame, rsp_last_frame);
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_number", FRAME_W'(want.number),
                           FRAME_W'(rsp_frame_number));
               check_field("lane_a_frame", want.lane_a, rsp_lane_a_frame);
               check_field("lane_b_frame", want.lane_b, rsp_lane_b_frame);
               check_field("last_frame", FRAME_W'(want.last), FRAME_W'(rsp_last_frame));
            end
         end
      end
      pending = expected_frames.size();
   end

endmodule

// ===== verif/dual_lane_rffe_write_framer_test.sv =====
`timescale 1ns / 1ps
// Top of the dual-lane RFFE framer testbench: clock, reset, item and register
// stimulus, receiver stalls and the verdict. Depends on rffefrm_pkg,
// dual_lane_rffe_write_framer and rffe_frame_checker.

module dual_lane_rffe_write_framer_test;
   import rffefrm_pkg::*;

   localparam int LIMIT_CYCLES   = 200000;
   localparam int HOLDOFF_CYCLES = 80;
   localparam int TAIL_CYCLES    = 8;
   localparam int PHASE_ITEMS    = 60;
   localparam int NUM_PHASES     = 6;
   localparam int IDLE_PERCENT   = 12;

   logic clock = 1'b0;
   logic reset;

   logic                 req_valid;
   logic                 req_stall;
   logic [DATA_W-1:0]    req_first_lane_a_value;
   logic [DATA_W-1:0]    req_first_lane_b_value;
   logic [DATA_W-1:0]    req_second_lane_a_value;
   logic [DATA_W-1:0]    req_second_lane_b_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [FNUM_W-1:0]    rsp_frame_number;
   logic [FRAME_W-1:0]   rsp_lane_a_frame;
   logic [FRAME_W-1:0]   rsp_lane_b_frame;
   logic                 rsp_last_frame;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   int fail_count;
   int pending;
   int cycles = 0;
   bit calm = 1'b0;
   bit holdoff_go = 1'b0;

   always #10 clock = ~clock;

   dual_lane_rffe_write_framer dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_first_lane_a_value  (req_first_lane_a_value),
      .req_first_lane_b_value  (req_first_lane_b_value),
      .req_second_lane_a_value (req_second_lane_a_value),
      .req_second_lane_b_value (req_second_lane_b_value),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_frame_number        (rsp_frame_number),
      .rsp_lane_a_frame        (rsp_lane_a_frame),
      .rsp_lane_b_frame        (rsp_lane_b_frame),
      .rsp_last_frame          (rsp_last_frame),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   rffe_frame_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_first_lane_a_value  (req_first_lane_a_value),
      .req_first_lane_b_value  (req_first_lane_b_value),
      .req_second_lane_a_value (req_second_lane_a_value),
      .req_second_lane_b_value (req_second_lane_b_value),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_frame_number        (rsp_frame_number),
      .rsp_lane_a_frame        (rsp_lane_a_frame),
      .rsp_lane_b_frame        (rsp_lane_b_frame),
      .rsp_last_frame          (rsp_last_frame),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .fail_count              (fail_count),
      .pending                 (pending)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("dual_lane_rffe_write_framer_test failed");
         $finish;
      end
   end

   // frame receiver: random stalls, or one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_go) begin
            holdoff_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // leaves req_valid high; the caller lowers it when the burst ends
   task automatic send_state(input logic [DATA_W-1:0] a0, input logic [DATA_W-1:0] b0,
                             input logic [DATA_W-1:0] a1, input logic [DATA_W-1:0] b1);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_lane_a_value  <= a0;
      req_first_lane_b_value  <= b0;
      req_second_lane_a_value <= a1;
      req_second_lane_b_value <= b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_state();
      send_state(DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)),
                 DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)));
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // full 8-bit write data also checks masking of the narrow registers;
   // the unused indexes must be ignored
   task automatic load_settings(input logic [DATA_W-1:0] first_id, input logic [DATA_W-1:0] second_id,
                                input logic [DATA_W-1:0] trig_addr, input logic [DATA_W-1:0] trig_val,
                                input logic [DATA_W-1:0] data_addr);
      write_reg(REG_FIRST_DEVICE_ID, first_id);
      write_reg(REG_SECOND_DEVICE_ID, second_id);
      write_reg(REG_TRIGGER_ADDRESS, trig_addr);
      write_reg(REG_TRIGGER_VALUE, trig_val);
      write_reg(REG_DATA_ADDRESS, data_addr);
      for (int i = REG_DATA_ADDRESS + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(i[CSR_IDX_W-1:0], DATA_W'($urandom_range(255)));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [DATA_W-1:0] bit_mask;
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_lane_a_value = '0;
      req_first_lane_b_value = '0;
      req_second_lane_a_value = '0;
      req_second_lane_b_value = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: extremes and walking bits on every lane
      send_state(8'h00, 8'h00, 8'h00, 8'h00);
      send_state(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_state(8'h55, 8'hAA, 8'h55, 8'hAA);
      send_state(8'hAA, 8'h55, 8'hAA, 8'h55);
      for (int i = 0; i < DATA_W; i++) begin
         bit_mask = DATA_W'(1) << i;
         send_state(bit_mask, ~bit_mask, bit_mask << 1 | bit_mask >> (DATA_W - 1), ~bit_mask);
      end
      drain_frames();

      load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_state(8'h00, 8'hFF, 8'h0F, 8'hF0);
      send_state(8'hFF, 8'h00, 8'hF0, 8'h0F);
      drain_frames();
      load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_state(8'h00, 8'hFF, 8'h0F, 8'hF0);
      send_state(8'hFF, 8'h00, 8'hF0, 8'h0F);
      drain_frames();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            NUM_PHASES - 2: load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            NUM_PHASES - 1: load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            default: load_settings(DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)),
                                   DATA_W'($urandom_range(255)), DATA_W'($urandom_range(255)),
                                   DATA_W'($urandom_range(255)));
         endcase
         calm = (phase == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off so the block backs up into the item input
            if (phase == 2 && n == 20)
               holdoff_go = 1'b1;
            // sender waits until every frame is out
            if (phase == 3 && n == 30)
               drain_frames();
            send_random_state();
         end
         calm = 1'b0;
         drain_frames();
      end

      if (fail_count == 0) begin
         $display("dual_lane_rffe_write_framer_test passed");
      end else begin
         $display("dual_lane_rffe_write_framer_test failed");
      end
      $finish;
   end

endmodule
